// File: src/borf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// borf_pkg: shared types for the block offset range fill core
// Transaction payloads, field widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package borf_pkg;

    localparam int unsigned IN_W     = 32;
    localparam int unsigned CARD_W   = 29;
    localparam int unsigned FILL_W   = 8;
    localparam int unsigned CFG_W    = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;

    typedef struct packed {
        logic [IN_W-1:0] block_start;
        logic [IN_W-1:0] block_end;
    } item_t;

    typedef struct packed {
        logic [CARD_W-1:0] first_card;
        logic [CARD_W-1:0] final_card;
        logic [FILL_W-1:0] fill_value;
        logic              skipped;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic load;
        logic align;
        logic first;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic first_last;
        logic range_last;
    } dp_sts_t;

endpackage
`default_nettype wire

// File: src/borf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// borf_ctrl: sequencer for the range fill run
// Steps through load, alignment, first fill and the backskip ranges.
// ----------------------------------------------------------------------------
module borf_ctrl
    import borf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALIGN = 4'b0010,
        S_FIRST = 4'b0100,
        S_RANGE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                cmd.first  = 1'b1;
                state_next = sts.first_last ? S_IDLE : S_RANGE;
            end
            S_RANGE:
            begin
                cmd.step = 1'b1;
                if (sts.range_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: src/borf_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// borf_dpath: card arithmetic and result register
// Aligns the block start, forms the first fill and walks the backskip ranges.
// ----------------------------------------------------------------------------
module borf_dpath
    import borf_pkg::*;
#(
    parameter int unsigned NUM_POWERS = 14,
    parameter int unsigned LOG_BASE   = 3,
    parameter int unsigned ADDR_W     = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire item_t            item,
    input  wire dp_cmd_t          cmd,
    output dp_sts_t               sts,
    output result_t               result,
    output logic                  strobe
);

    localparam int unsigned BW    = ADDR_W + 1 + LOG_BASE;
    localparam int unsigned IDX_W = (NUM_POWERS > 1) ? $clog2(NUM_POWERS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_POWERS - 1);

    logic [CFG_W-1:0]  cwl_reg;
    logic [ADDR_W-1:0] bs_reg;
    logic [ADDR_W-1:0] be_reg;
    logic [ADDR_W-1:0] be_m1_reg;
    logic [ADDR_W:0]   boundary_reg;
    logic [ADDR_W:0]   ocard_reg;
    logic [ADDR_W-1:0] ecard_reg;
    logic [ADDR_W:0]   region_reg;
    logic [BW-1:0]     back_m1_reg;
    logic [IDX_W-1:0]  idx_reg;
    result_t           res_reg;
    logic              strobe_reg;

    logic [FILL_W-1:0] cw;
    logic [ADDR_W:0]   cw_ext;
    logic [ADDR_W:0]   cw_m1;
    logic [ADDR_W:0]   boundary_next;
    logic [ADDR_W:0]   ocard;
    logic [ADDR_W-1:0] ecard;
    logic              no_cross;
    logic              more_cards;
    logic [BW:0]       reach;
    logic              hit;
    logic              run_end;
    logic [BW-1:0]     back_m1_next;
    result_t           res_next;

    assign cw     = FILL_W'(1) << cwl_reg;
    assign cw_ext = (ADDR_W+1)'(cw);
    assign cw_m1  = cw_ext - 1'b1;

    assign boundary_next = ({1'b0, bs_reg} + cw_m1) & ~cw_m1;

    assign ocard      = boundary_reg >> cwl_reg;
    assign ecard      = be_m1_reg >> cwl_reg;
    assign no_cross   = ({1'b0, be_reg} <= boundary_reg);
    assign more_cards = ((boundary_reg + cw_ext) < {1'b0, be_reg});

    assign reach   = (BW+1)'(ocard_reg) + (BW+1)'(back_m1_reg);
    assign hit     = (reach >= (BW+1)'(ecard_reg));
    assign run_end = hit || (idx_reg == IDX_LAST);

    assign back_m1_next = (|back_m1_reg[BW-1 -: LOG_BASE]) ? {BW{1'b1}} :
                          {back_m1_reg[BW-LOG_BASE-1:0], {LOG_BASE{1'b1}}};

    assign sts.first_last = no_cross || !more_cards;
    assign sts.range_last = run_end;

    always_comb
    begin
        res_next = res_reg;
        if (cmd.first)
        begin
            if (no_cross)
            begin
                res_next = '0;
                res_next.skipped     = 1'b1;
                res_next.last_of_run = 1'b1;
            end
            else
            begin
                res_next.first_card  = CARD_W'(ocard);
                res_next.final_card  = CARD_W'(ocard);
                res_next.fill_value  = FILL_W'(boundary_reg - {1'b0, bs_reg});
                res_next.skipped     = 1'b0;
                res_next.last_of_run = !more_cards;
            end
        end
        else if (cmd.step)
        begin
            res_next.first_card  = CARD_W'(region_reg);
            res_next.final_card  = hit ? CARD_W'(ecard_reg) : CARD_W'(reach);
            res_next.fill_value  = cw + FILL_W'(idx_reg);
            res_next.skipped     = 1'b0;
            res_next.last_of_run = run_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwl_reg    <= CFG_RESET;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cwl_reg <= cfg_data;
            end
            strobe_reg <= cmd.first | cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load)
        begin
            bs_reg <= item.block_start[ADDR_W-1:0];
            be_reg <= item.block_end[ADDR_W-1:0];
        end
        if (cmd.align)
        begin
            boundary_reg <= boundary_next;
            be_m1_reg    <= be_reg - 1'b1;
        end
        if (cmd.first)
        begin
            ocard_reg   <= ocard;
            ecard_reg   <= ecard;
            region_reg  <= ocard + 1'b1;
            back_m1_reg <= BW'({LOG_BASE{1'b1}});
            idx_reg     <= '0;
        end
        else if (cmd.step)
        begin
            region_reg  <= (ADDR_W+1)'(reach + 1'b1);
            back_m1_reg <= back_m1_next;
            idx_reg     <= idx_reg + 1'b1;
        end
    end

    assign result = res_reg;
    assign strobe = strobe_reg;

endmodule
`default_nettype wire

// File: src/block_offset_range_fill_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_offset_range_fill_core: card table range fills for one heap block
// Turns a block's word offsets into first-card offset and backskip fills.
//
//   Channel  Signals                   Transaction
//   -------  ------------------------  ---------------------------------
//   item     start, busy, item         start && !busy
//   result   strobe, result            strobe (one cycle, no stall)
//   config   cfg_valid, cfg_ready,     cfg_valid && cfg_ready
//            cfg_data
//
// An item runs through load, alignment of the start to a card boundary and the
// first fill, then the backskip ranges (0 to NUM_POWERS) from the sequencer's
// step loop. The first result is registered by the first-fill step and
// later results follow one per cycle.
// Reset sets card_words_log to 6 and returns the sequencer to idle.
// Results cannot be held off; a new item may be taken while the last one
// still sits in the output register.
// ----------------------------------------------------------------------------
module block_offset_range_fill_core
    import borf_pkg::*;
#(
    parameter int unsigned NUM_POWERS     = 14,
    parameter int unsigned LOG_BASE       = 3,
    parameter int unsigned WORD_ADDR_BITS = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire item_t            item,
    output logic                  strobe,
    output result_t               result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int unsigned ADDR_W = (WORD_ADDR_BITS < IN_W) ? WORD_ADDR_BITS : IN_W;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    busy_int;

    assign cfg_ready = 1'b1;
    assign busy      = busy_int;

    borf_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy_int),
        .cmd   (cmd),
        .sts   (sts)
    );

    borf_dpath #(
        .NUM_POWERS (NUM_POWERS),
        .LOG_BASE   (LOG_BASE),
        .ADDR_W     (ADDR_W)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result),
        .strobe   (strobe)
    );

endmodule
`default_nettype wire

// File: sim/tb_block_offset_range_fill_core.sv
// ----------------------------------------------------------------------------
// tb_block_offset_range_fill_core: self-checking bench for the range fill core
// Drives heap blocks through the start/busy port under several card sizes and
// sender idle patterns. It predicts the first-card offset and backskip fills
// of every accepted block and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_block_offset_range_fill_core;
    import borf_pkg::*;

    localparam int unsigned N_POW       = 14;
    localparam int unsigned LOG_B       = 3;
    localparam int unsigned ADDR_BITS   = 32;
    localparam int unsigned N_PHASES    = 8;
    localparam int unsigned PER_PHASE   = 56;
    localparam int unsigned SETTLE      = 20;
    localparam int unsigned MAX_REPORTS = 10;

    class fill_tracker;
        result_t     pending_fills[$];
        logic [CFG_W-1:0] cw_log;
        int unsigned mismatches;
        int unsigned fills_checked;
        int unsigned skipped_blocks;

        function new();
            cw_log         = CFG_RESET;
            mismatches     = 0;
            fills_checked  = 0;
            skipped_blocks = 0;
        endfunction

        function void note_block(item_t blk);
            logic [63:0] bs;
            logic [63:0] be;
            logic [63:0] cw;
            logic [63:0] boundary;
            logic [63:0] ocard;
            logic [63:0] ecard;
            logic [63:0] rstart;
            logic [63:0] region;
            logic [63:0] reach;
            logic [63:0] span;
            int unsigned ex;
            result_t     r;
            result_t     run[$];
            bs = 64'(blk.block_start);
            be = 64'(blk.block_end);
            cw = 64'd1 << cw_log;
            boundary = (bs + cw - 64'd1) & ~(cw - 64'd1);
            if (be <= boundary)
            begin
                r = '0;
                r.skipped     = 1'b1;
                r.last_of_run = 1'b1;
                pending_fills.push_back(r);
                return;
            end
            ocard = boundary >> cw_log;
            r = '0;
            r.first_card = ocard[CARD_W-1:0];
            r.final_card = ocard[CARD_W-1:0];
            r.fill_value = FILL_W'(boundary - bs);
            run.push_back(r);
            ecard = (be - 64'd1) >> cw_log;
            if (ocard + 64'd1 <= ecard)
            begin
                rstart = ocard + 64'd1;
                region = rstart;
                for (int i = 0; i < N_POW; i++)
                begin
                    ex     = LOG_B * (i + 1);
                    span   = 64'd1 << (ex < 62 ? ex : 62);
                    reach  = rstart - 64'd1 + (span - 64'd1);
                    r      = '0;
                    r.first_card = region[CARD_W-1:0];
                    r.fill_value = FILL_W'(cw + 64'(i));
                    if (reach >= ecard)
                    begin
                        r.final_card = ecard[CARD_W-1:0];
                        run.push_back(r);
                        break;
                    end
                    r.final_card = reach[CARD_W-1:0];
                    run.push_back(r);
                    region = reach + 64'd1;
                end
            end
            run[run.size()-1].last_of_run = 1'b1;
            foreach (run[k])
                pending_fills.push_back(run[k]);
        endfunction

        function void check_fill(result_t got);
            result_t want;
            if (pending_fills.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected fill first=%h final=%h val=%h skip=%b last=%b",
                             got.first_card, got.final_card, got.fill_value,
                             got.skipped, got.last_of_run);
                return;
            end
            want = pending_fills.pop_front();
            fills_checked++;
            if (want.skipped)
                skipped_blocks++;
            if (got.first_card !== want.first_card || got.final_card !== want.final_card ||
                got.fill_value !== want.fill_value || got.skipped !== want.skipped ||
                got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: fill mismatch exp first=%h final=%h val=%h skip=%b last=%b",
                              " got first=%h final=%h val=%h skip=%b last=%b"},
                             want.first_card, want.final_card, want.fill_value,
                             want.skipped, want.last_of_run,
                             got.first_card, got.final_card, got.fill_value,
                             got.skipped, got.last_of_run);
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    item_t            blk_in    = '0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             busy;
    logic             strobe;
    result_t          result;
    logic             cfg_ready;

    fill_tracker tracker = new();
    int unsigned blocks_sent = 0;

    block_offset_range_fill_core #(
        .NUM_POWERS    (N_POW),
        .LOG_BASE      (LOG_B),
        .WORD_ADDR_BITS(ADDR_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (blk_in),
        .strobe   (strobe),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            tracker.check_fill(result);
    end

    task automatic send_block(input logic [31:0] bs, input logic [31:0] be,
                              input int unsigned idle_pct);
        item_t blk;
        blk.block_start = bs;
        blk.block_end   = be;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start  <= 1'b1;
        blk_in <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_block(blk);
        blocks_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending_fills.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_card_size(input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.cw_log = val;
    endtask

    task automatic send_random_block(input int unsigned idle_pct);
        logic [31:0] bs;
        logic [31:0] be;
        logic [31:0] len;
        int unsigned w;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            bs = $urandom;
            be = $urandom;
        end
        else if (kind < 22)
        begin
            bs = $urandom;
            be = bs + $urandom_range(0, 32'd1 << tracker.cw_log);
        end
        else
        begin
            bs  = $urandom >> $urandom_range(0, 31);
            w   = $urandom_range(1, 32);
            len = (w == 32) ? $urandom : ($urandom & ((32'd1 << w) - 32'd1));
            be  = bs + (len | 32'd1);
            if (be < bs)
                be = 32'hFFFF_FFFF;
        end
        send_block(bs, be, idle_pct);
    endtask

    task automatic send_directed();
        logic [31:0] cw;
        cw = 32'd1 << tracker.cw_log;
        send_block(32'd0, 32'd0, 0);
        send_block(32'd0, 32'd1, 0);
        send_block(32'd1, 32'd2, 0);
        send_block(32'd1, cw, 0);
        send_block(32'd1, cw + 32'd1, 0);
        send_block(32'd10, 32'd5, 0);
        send_block(32'd0, 2 * cw, 0);
        send_block(32'd0, 8 * cw, 0);
        send_block(32'd0, 9 * cw, 0);
        send_block(32'd0, 64 * cw, 0);
        send_block(32'd0, 65 * cw, 0);
        send_block(32'd0, 513 * cw + 32'd1, 0);
        send_block(cw - 32'd1, 600 * cw + 32'd3, 0);
        send_block(32'd0, 32'hFFFF_FFFF, 0);
        send_block(32'd1, 32'hFFFF_FFFF, 0);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_block(32'hFFFF_FFC1, 32'hFFFF_FFFF, 0);
        send_block(32'hFFFF_FFC0, 32'hFFFF_FFFF, 0);
        send_block(32'hFFFF_FFFF, 32'd0, 0);
        send_block(32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_block(32'h5555_5555, 32'hAAAA_AAAA, 0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] card_sizes[N_PHASES];
        int unsigned      idle_pcts[N_PHASES];
        card_sizes = '{3'd6, 3'd3, 3'd7, 3'd0, 3'd5, 3'd1, 3'd2, 3'd4};
        idle_pcts  = '{0, 73, 29, 0, 73, 29, 73, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                write_card_size(card_sizes[p]);
            end
            for (int n = 0; n < PER_PHASE; n++)
                send_random_block(idle_pcts[p]);
        end
        drain();
        $display("Covered %0d blocks across %0d card sizes with mixed sender gaps",
                 blocks_sent, N_PHASES);
        $display("Checked %0d fill commands, %0d from blocks crossing no card boundary",
                 tracker.fills_checked, tracker.skipped_blocks);
        if (tracker.mismatches == 0 && tracker.pending_fills.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/borf_pkg.sv
src/borf_ctrl.sv
src/borf_dpath.sv
src/block_offset_range_fill_core.sv
sim/tb_block_offset_range_fill_core.sv
